// ----- rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Types and constants shared by the key-value cache modules.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;
    localparam int QDEPTH = 2;

    localparam logic [CFG_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic              CMD_GET    = 1'b0;
    localparam logic              CMD_PUT    = 1'b1;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // request as seen on the input channel
    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // result of a get
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } rsp_t;

    // classified request held in the queue
    typedef struct packed {
        logic              is_put;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } qitem_t;

    // queue head as offered to the engine
    typedef struct packed {
        logic   valid;
        qitem_t item;
    } qhead_t;

endpackage

// ----- rtl/lkv_front.sv -----
// ----------------------------------------------------------------------------
// lkv_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module lkv_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lkv_pkg::req_t req,
    input  logic          pop,
    output lkv_pkg::qhead_t head
);
    import lkv_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    qitem_t             qmem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pull;
    qitem_t             cls_item;

    assign req_ready = (count_reg != CNT_W'(QDEPTH));
    assign push      = req_valid && req_ready;
    assign pull      = pop && (count_reg != '0);

    always_comb
    begin
        cls_item.is_put = (req.command == CMD_PUT);
        cls_item.key    = req.key;
        cls_item.value  = req.value;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pull)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pull)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pull && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qmem_reg[wr_ptr_reg] <= cls_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = qmem_reg[rd_ptr_reg];

endmodule

// ----- rtl/lkv_engine.sv -----
// ----------------------------------------------------------------------------
// lkv_engine
// Scans the entry store for one request, then updates it and returns a get's result.
// ----------------------------------------------------------------------------
module lkv_engine
#(
    parameter int ENTRIES = 16,
    parameter int CAP_W   = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CAP_W-1:0] cap,
    input  lkv_pkg::qhead_t  head,
    output logic             pop,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output lkv_pkg::rsp_t    rsp
);
    import lkv_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [DATA_W-1:0] key_mem [ENTRIES];
    logic [DATA_W-1:0] val_mem [ENTRIES];

    logic [2:0]        state_reg, state_next;
    qitem_t            cur_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic              chk_vld_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic [DATA_W-1:0] key_rd_reg;
    logic [DATA_W-1:0] val_rd_reg;
    logic              match_found_reg, free_found_reg, old_found_reg;
    logic [IDX_W-1:0]  match_idx_reg, free_idx_reg, old_idx_reg;
    logic              valid_reg [ENTRIES];
    logic [IDX_W-1:0]  rank_reg  [ENTRIES];
    logic [CNT_W-1:0]  occ_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_data_reg;

    logic              start;
    logic              exec;
    logic              load_rsp;
    logic [IDX_W-1:0]  occ_m1;
    logic              chk_match, chk_free, chk_old;
    logic              miss_put;
    logic              do_fill, do_evict, do_touch;
    logic              wr_key, wr_val;
    logic [IDX_W-1:0]  tgt_idx;
    logic [IDX_W-1:0]  touch_rank;

    assign start    = (state_reg == ST_IDLE) && head.valid;
    assign exec     = (state_reg == ST_EXEC);
    assign load_rsp = (state_reg == ST_OUT) && (!rsp_valid_reg || rsp_ready);
    assign pop      = start;

    // ------------------------------------------------------------------ fsm
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = cur_reg.is_put ? ST_IDLE : ST_OUT;
            end
            ST_OUT:
            begin
                if (load_rsp)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------ per-entry check
    // one entry per cycle; key read data is registered, and the index is registered alongside it
    assign occ_m1    = IDX_W'(occ_reg - 1'b1);
    assign chk_match = chk_vld_reg && valid_reg[chk_idx_reg] && (key_rd_reg == cur_reg.key);
    assign chk_free  = chk_vld_reg && !valid_reg[chk_idx_reg];
    assign chk_old   = chk_vld_reg && valid_reg[chk_idx_reg] && (rank_reg[chk_idx_reg] == occ_m1);

    // --------------------------------------------------------- update plan
    assign miss_put   = cur_reg.is_put && !match_found_reg;
    assign do_fill    = exec && miss_put && (CAP_W'(occ_reg) < cap) && free_found_reg;
    assign do_evict   = exec && miss_put && !do_fill && old_found_reg;
    assign do_touch   = (exec && match_found_reg) || do_evict;
    assign wr_key     = do_fill || do_evict;
    assign wr_val     = (exec && cur_reg.is_put && match_found_reg) || wr_key;
    assign tgt_idx    = match_found_reg ? match_idx_reg :
                        (do_fill ? free_idx_reg : old_idx_reg);
    assign touch_rank = rank_reg[tgt_idx];

    // ------------------------------------------------------ control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            scan_idx_reg    <= '0;
            chk_vld_reg     <= 1'b0;
            chk_idx_reg     <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            old_found_reg   <= 1'b0;
            match_idx_reg   <= '0;
            free_idx_reg    <= '0;
            old_idx_reg     <= '0;
            occ_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                valid_reg[j] <= 1'b0;
                rank_reg[j]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            chk_vld_reg   <= (state_reg == ST_SCAN);
            chk_idx_reg   <= scan_idx_reg;

            if (start)
            begin
                scan_idx_reg    <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                old_found_reg   <= 1'b0;
            end
            else
            begin
                if (state_reg == ST_SCAN)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (chk_match)
                begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= chk_idx_reg;
                end
                if (chk_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= chk_idx_reg;
                end
                if (chk_old)
                begin
                    old_found_reg <= 1'b1;
                    old_idx_reg   <= chk_idx_reg;
                end
            end

            // recency: a fill ages every valid entry, a touch ages the younger ones
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (IDX_W'(j) == tgt_idx && (do_fill || do_touch))
                begin
                    rank_reg[j]  <= '0;
                    valid_reg[j] <= 1'b1;
                end
                else if (do_fill && valid_reg[j])
                begin
                    rank_reg[j] <= rank_reg[j] + 1'b1;
                end
                else if (do_touch && valid_reg[j] && rank_reg[j] < touch_rank)
                begin
                    rank_reg[j] <= rank_reg[j] + 1'b1;
                end
            end

            if (do_fill)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------ payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= head.item;
        end
        if (load_rsp)
        begin
            rsp_data_reg.hit        <= match_found_reg;
            rsp_data_reg.read_value <= match_found_reg ? val_rd_reg : MISS_VALUE;
        end
    end

    // ------------------------------------------------------------ memories
    always_ff @(posedge clk)
    begin
        if (wr_key)
        begin
            key_mem[tgt_idx] <= cur_reg.key;
        end
        key_rd_reg <= key_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_val)
        begin
            val_mem[tgt_idx] <= cur_reg.value;
        end
        if (exec)
        begin
            val_rd_reg <= val_mem[tgt_idx];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

endmodule

// ----- rtl/lru_key_value_cache_unit.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready); a transfer takes place when req_valid
// and req_ready are both high. A get (command 0) yields one transfer on rsp:
// hit and the stored value, or hit clear and all ones. A put (command 1)
// yields nothing. cfg_we writes the capacity register (0 acts as 1, above
// ENTRIES acts as ENTRIES); write it only while the block is idle.
// A two-entry queue sits behind req, so requests are taken while the engine
// works or while a result waits on rsp.
// The engine handles one request at a time: it scans the key store one entry
// per cycle through its single read port, then goes through its drain and
// exec states, updating the store in exec; a get then waits in the out state
// until its result is loaded into the rsp register.
// Reset empties the cache and the queue and sets capacity to 16. When rsp is
// stalled the result holds in its register, the engine waits, and req_ready
// drops once the queue is full.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
#(
    parameter int ENTRIES = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  lkv_pkg::req_t           req,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output lkv_pkg::rsp_t           rsp,
    input  logic                    cfg_we,
    input  logic [lkv_pkg::CFG_W-1:0] cfg_wdata
);
    import lkv_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_ext;
    logic [CAP_W-1:0] cap_eff;
    qhead_t           head;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    assign cap_ext = CAP_W'(cap_reg);

    always_comb
    begin
        if (cap_ext == '0)
        begin
            cap_eff = CAP_W'(1);
        end
        else if (cap_ext > CAP_W'(ENTRIES))
        begin
            cap_eff = CAP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    lkv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pop       (pop),
        .head      (head)
    );

    lkv_engine
    #(
        .ENTRIES (ENTRIES),
        .CAP_W   (CAP_W)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_eff),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
